### hw/rtl/stt_pkg.sv
`timescale 1ns / 1ps

package stt_pkg;

   localparam int MAX_TEXT_DEF = 32;

   localparam int KW_NUM  = 9;
   localparam int KW_BITS = 112;

   localparam logic [4:0] K_COLON    = 5'd0;
   localparam logic [4:0] K_DASH     = 5'd1;
   localparam logic [4:0] K_STRING   = 5'd2;
   localparam logic [4:0] K_INT      = 5'd3;
   localparam logic [4:0] K_IDENT    = 5'd4;
   localparam logic [4:0] K_KEYWORD0 = 5'd5;
   localparam logic [4:0] K_TAB      = 5'd14;
   localparam logic [4:0] K_BLANK    = 5'd15;
   localparam logic [4:0] K_NEWLINE  = 5'd16;

   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_SYMBOL = 2'd1;
   localparam logic [1:0] ERR_TRUNC  = 2'd2;
   localparam logic [1:0] ERR_QUOTE  = 2'd3;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [4:0]  token_kind;
      logic [31:0] int_value;
      logic [7:0]  text_char;
      logic        text_valid;
      logic        token_end;
      logic [1:0]  error_code;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic emit_pre;
      logic emit_rep;
      logic emit_post;
      logic rd_first;
      logic rd_next;
   } cmd_type;

   typedef struct packed {
      logic plan_pre;
      logic plan_rep;
      logic plan_post;
      logic post_valid;
      logic rep_last;
      logic out_free;
   } sts_type;

   localparam logic [5:0] KW_LEN [KW_NUM] = '{
      6'd4, 6'd2, 6'd3, 6'd4, 6'd14, 6'd6, 6'd4, 6'd5, 6'd8
   };

   localparam logic [KW_BITS-1:0] KW_TEXT [KW_NUM] = '{
      "meta", "id", "seq", "type", "file-extension",
      "endian", "size", "types", "contents"
   };

   // character of keyword k at position pos, zero past its end
   function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [5:0] pos);
      logic [KW_BITS-1:0] txt;
      logic [5:0]         len;
      int                 sh;
      txt = KW_TEXT[k];
      len = KW_LEN[k];
      sh  = int'(len - pos - 6'd1) * 8;
      if (pos >= len) begin
         kw_char = 8'h00;
      end else begin
         kw_char = txt[sh +: 8];
      end
   endfunction

   function automatic rsp_type make_rsp(input logic [4:0] kind, input logic [31:0] ival,
                                        input logic [7:0] ch, input logic tv,
                                        input logic tend, input logic [1:0] err);
      rsp_type r;
      r.token_kind = kind;
      r.int_value  = ival;
      r.text_char  = ch;
      r.text_valid = tv;
      r.token_end  = tend;
      r.error_code = err;
      r.last       = 1'b0;
      make_rsp = r;
   endfunction

endpackage

### hw/rtl/schema_text_tokenizer.sv
// An accepted byte's results are planned into registers and leave through the registered output;
// a byte with no result leaves the lexer idle, else req_stall holds off new bytes until every
// result is out, and an identifier or string replay first reads the text store in its own state.
// The text store has one read port, so replayed text leaves one byte per cycle while the output is not stalled.
// Reset (synchronous, active high) returns the lexer to idle with empty text and zero value.
`timescale 1ns / 1ps

module schema_text_tokenizer #(
   parameter int MAX_TEXT = stt_pkg::MAX_TEXT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  stt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output stt_pkg::rsp_type rsp_data
);

   stt_pkg::cmd_type cmd;
   stt_pkg::sts_type sts;

   stt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   stt_dp #(
      .MAX_TEXT (MAX_TEXT)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

### hw/rtl/stt_ctrl.sv
`timescale 1ns / 1ps

module stt_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  stt_pkg::sts_type sts,
   output stt_pkg::cmd_type cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PRE  = 3'd1;
   localparam logic [2:0] ST_RDF  = 3'd2;
   localparam logic [2:0] ST_REP  = 3'd3;
   localparam logic [2:0] ST_POST = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (sts.plan_pre) begin
                  state_in = ST_PRE;
               end else if (sts.plan_rep) begin
                  state_in = ST_RDF;
               end else if (sts.plan_post) begin
                  state_in = ST_POST;
               end
            end
         end
         ST_PRE: begin
            if (sts.out_free) begin
               cmd.emit_pre = 1'b1;
               state_in     = sts.post_valid ? ST_POST : ST_IDLE;
            end
         end
         ST_RDF: begin
            cmd.rd_first = 1'b1;
            state_in     = ST_REP;
         end
         ST_REP: begin
            if (sts.out_free) begin
               cmd.emit_rep = 1'b1;
               if (sts.rep_last) begin
                  state_in = sts.post_valid ? ST_POST : ST_IDLE;
               end else begin
                  cmd.rd_next = 1'b1;
               end
            end
         end
         ST_POST: begin
            if (sts.out_free) begin
               cmd.emit_post = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hw/rtl/stt_dp.sv
`timescale 1ns / 1ps

module stt_dp #(
   parameter int MAX_TEXT = stt_pkg::MAX_TEXT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  stt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output stt_pkg::rsp_type rsp_data,
   input  stt_pkg::cmd_type cmd,
   output stt_pkg::sts_type sts
);

   localparam int AW = $clog2(MAX_TEXT);
   localparam int LW = $clog2(MAX_TEXT + 1);

   localparam logic [2:0] MODE_IDLE   = 3'd0;
   localparam logic [2:0] MODE_WORD   = 3'd1;
   localparam logic [2:0] MODE_NUMBER = 3'd2;
   localparam logic [2:0] MODE_STRING = 3'd3;
   localparam logic [2:0] MODE_SPACE  = 3'd4;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QUOTE = 8'h27;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UZ    = 8'h5A;
   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LZ    = 8'h7A;

   // lexer state
   logic [2:0]                mode_ff, mode_in;
   logic [LW-1:0]             len_ff, len_in;
   logic [31:0]               acc_ff, acc_in;
   logic                      trunc_ff, trunc_in;
   logic [stt_pkg::KW_NUM-1:0] match_ff, match_in;

   // result plan of the accepted byte
   logic             pre_valid_in;
   stt_pkg::rsp_type pre_rsp_ff, pre_rsp_in;
   logic             rep_valid_in;
   logic [4:0]       rep_kind_ff, rep_kind_in;
   logic [LW-1:0]    rep_len_ff;
   logic [1:0]       rep_err_ff, rep_err_in;
   logic             post_valid_ff, post_valid_in;
   stt_pkg::rsp_type post_rsp_ff, post_rsp_in;

   // text store and replay
   logic [7:0]    text_mem [MAX_TEXT];
   logic [7:0]    rd_data_ff;
   logic [AW-1:0] rd_idx_ff;
   logic [AW-1:0] rd_addr;
   logic [LW-1:0] idx_inc;
   logic          wr_en;
   logic [AW-1:0] wr_addr;

   logic             rsp_valid_ff;
   stt_pkg::rsp_type rsp_ff, rsp_in;

   logic [7:0]    c;
   logic          eoi;
   logic          is_digit;
   logic          is_letter;
   logic          kw_hit;
   logic [4:0]    kw_kind;
   logic          text_clear;
   logic          text_append;
   logic [LW-1:0] base_len;
   logic [stt_pkg::KW_NUM-1:0] base_match;
   logic          flush;
   logic          lex;
   logic          out_free;
   logic          rep_last;

   assign c         = req_data.in_byte;
   assign eoi       = req_data.end_of_input || (c == CH_NUL);
   assign is_digit  = c inside {[CH_0:CH_9]};
   assign is_letter = (c inside {[CH_LA:CH_LZ], [CH_UA:CH_UZ]}) || (c == CH_UNDER);

   always_comb begin
      kw_hit  = 1'b0;
      kw_kind = stt_pkg::K_KEYWORD0;
      for (int k = 0; k < stt_pkg::KW_NUM; k++) begin
         if (match_ff[k] && (len_ff == LW'(stt_pkg::KW_LEN[k]))) begin
            kw_hit  = 1'b1;
            kw_kind = stt_pkg::K_KEYWORD0 + 5'(k);
         end
      end
      kw_hit = kw_hit && !trunc_ff;
   end

   always_comb begin
      mode_in       = mode_ff;
      acc_in        = acc_ff;
      pre_valid_in  = 1'b0;
      pre_rsp_in    = stt_pkg::make_rsp(stt_pkg::K_COLON, 32'd0, 8'h00, 1'b0, 1'b1,
                                        stt_pkg::ERR_NONE);
      rep_valid_in  = 1'b0;
      rep_kind_in   = stt_pkg::K_IDENT;
      rep_err_in    = trunc_ff ? stt_pkg::ERR_TRUNC : stt_pkg::ERR_NONE;
      post_valid_in = 1'b0;
      post_rsp_in   = stt_pkg::make_rsp(stt_pkg::K_COLON, 32'd0, 8'h00, 1'b0, 1'b1,
                                        stt_pkg::ERR_NONE);
      text_clear    = 1'b0;
      text_append   = 1'b0;
      flush         = 1'b0;
      lex           = 1'b0;

      if (eoi) begin
         flush      = 1'b1;
         mode_in    = MODE_IDLE;
         text_clear = 1'b1;
         acc_in     = 32'd0;
         if (mode_ff == MODE_STRING) begin
            pre_valid_in = 1'b1;
            pre_rsp_in   = stt_pkg::make_rsp(stt_pkg::K_STRING, 32'd0, 8'h00, 1'b0, 1'b1,
                                             stt_pkg::ERR_QUOTE);
         end
      end else if (mode_ff == MODE_STRING) begin
         if (c == CH_QUOTE) begin
            mode_in = MODE_IDLE;
            if (len_ff == '0) begin
               pre_valid_in = 1'b1;
               pre_rsp_in   = stt_pkg::make_rsp(stt_pkg::K_STRING, 32'd0, 8'h00, 1'b0,
                                                1'b1, rep_err_in);
            end else begin
               rep_valid_in = 1'b1;
               rep_kind_in  = stt_pkg::K_STRING;
            end
         end else begin
            text_append = 1'b1;
         end
      end else if (mode_ff == MODE_WORD && (is_letter || is_digit || c == CH_DASH)) begin
         text_append = 1'b1;
      end else if (mode_ff == MODE_NUMBER && is_digit) begin
         acc_in = (acc_ff << 3) + (acc_ff << 1) + 32'(8'(c - CH_0));
      end else if (mode_ff == MODE_SPACE && c == CH_SPACE) begin
         pre_valid_in = 1'b1;
         pre_rsp_in   = stt_pkg::make_rsp(stt_pkg::K_TAB, 32'd0, 8'h00, 1'b0, 1'b1,
                                          stt_pkg::ERR_NONE);
         mode_in      = MODE_IDLE;
      end else begin
         flush   = 1'b1;
         lex     = 1'b1;
         mode_in = MODE_IDLE;
         if (mode_ff == MODE_SPACE) begin
            pre_valid_in = 1'b1;
            pre_rsp_in   = stt_pkg::make_rsp(stt_pkg::K_BLANK, 32'd0, 8'h00, 1'b0, 1'b1,
                                             stt_pkg::ERR_NONE);
         end
      end

      if (flush) begin
         if (mode_ff == MODE_WORD) begin
            if (kw_hit) begin
               pre_valid_in = 1'b1;
               pre_rsp_in   = stt_pkg::make_rsp(kw_kind, 32'd0, 8'h00, 1'b0, 1'b1,
                                                stt_pkg::ERR_NONE);
            end else begin
               rep_valid_in = 1'b1;
               rep_kind_in  = stt_pkg::K_IDENT;
            end
         end else if (mode_ff == MODE_NUMBER) begin
            pre_valid_in = 1'b1;
            pre_rsp_in   = stt_pkg::make_rsp(stt_pkg::K_INT, acc_ff, 8'h00, 1'b0, 1'b1,
                                             stt_pkg::ERR_NONE);
         end
      end

      if (lex) begin
         if (c == CH_COLON) begin
            post_valid_in = 1'b1;
         end else if (c == CH_DASH) begin
            post_valid_in          = 1'b1;
            post_rsp_in.token_kind = stt_pkg::K_DASH;
         end else if (c == CH_TAB) begin
            post_valid_in          = 1'b1;
            post_rsp_in.token_kind = stt_pkg::K_TAB;
         end else if (c == CH_LF) begin
            post_valid_in          = 1'b1;
            post_rsp_in.token_kind = stt_pkg::K_NEWLINE;
         end else if (c == CH_CR) begin
            post_valid_in = 1'b0;
         end else if (c == CH_SPACE) begin
            mode_in = MODE_SPACE;
         end else if (c == CH_QUOTE) begin
            text_clear = 1'b1;
            mode_in    = MODE_STRING;
         end else if (is_digit) begin
            acc_in  = 32'(8'(c - CH_0));
            mode_in = MODE_NUMBER;
         end else if (is_letter) begin
            text_clear  = 1'b1;
            text_append = 1'b1;
            mode_in     = MODE_WORD;
         end else begin
            post_valid_in          = 1'b1;
            post_rsp_in.error_code = stt_pkg::ERR_SYMBOL;
         end
      end
   end

   always_comb begin
      base_len   = text_clear ? '0 : len_ff;
      base_match = text_clear ? '1 : match_ff;
      len_in     = base_len;
      trunc_in   = text_clear ? 1'b0 : trunc_ff;
      match_in   = base_match;
      wr_en      = 1'b0;
      wr_addr    = base_len[AW-1:0];
      if (text_append) begin
         if (base_len < LW'(MAX_TEXT)) begin
            wr_en  = 1'b1;
            len_in = base_len + LW'(1);
            for (int k = 0; k < stt_pkg::KW_NUM; k++) begin
               match_in[k] = base_match[k] && (6'(base_len) < stt_pkg::KW_LEN[k]) &&
                             (c == stt_pkg::kw_char(4'(k), 6'(base_len)));
            end
         end else begin
            trunc_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         len_ff        <= '0;
         acc_ff        <= 32'd0;
         trunc_ff      <= 1'b0;
         post_valid_ff <= 1'b0;
      end else if (cmd.accept) begin
         mode_ff       <= mode_in;
         len_ff        <= len_in;
         acc_ff        <= acc_in;
         trunc_ff      <= trunc_in;
         post_valid_ff <= post_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         match_ff    <= match_in;
         pre_rsp_ff  <= pre_rsp_in;
         rep_kind_ff <= rep_kind_in;
         rep_len_ff  <= len_ff;
         rep_err_ff  <= rep_err_in;
         post_rsp_ff <= post_rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && wr_en) begin
         text_mem[wr_addr] <= c;
      end
   end

   assign idx_inc  = LW'(rd_idx_ff) + LW'(1);
   assign rd_addr  = cmd.rd_first ? '0 : idx_inc[AW-1:0];
   assign rep_last = (idx_inc == rep_len_ff);

   always_ff @(posedge clock) begin
      if (cmd.rd_first || cmd.rd_next) begin
         rd_data_ff <= text_mem[rd_addr];
         rd_idx_ff  <= rd_addr;
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_pre || cmd.emit_rep || cmd.emit_post) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.emit_pre) begin
         rsp_in      = pre_rsp_ff;
         rsp_in.last = !post_valid_ff;
      end else if (cmd.emit_rep) begin
         rsp_in = stt_pkg::make_rsp(rep_kind_ff, 32'd0, rd_data_ff, 1'b1, rep_last,
                                    rep_last ? rep_err_ff : stt_pkg::ERR_NONE);
         rsp_in.last = rep_last && !post_valid_ff;
      end else if (cmd.emit_post) begin
         rsp_in      = post_rsp_ff;
         rsp_in.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      sts.plan_pre   = pre_valid_in;
      sts.plan_rep   = rep_valid_in;
      sts.plan_post  = post_valid_in;
      sts.post_valid = post_valid_ff;
      sts.rep_last   = rep_last;
      sts.out_free   = out_free;
   end

endmodule

### bench/tb_schema_text_tokenizer.sv
`timescale 1ns / 1ps

module tb_schema_text_tokenizer;

   typedef enum logic [2:0] {
      SCAN_IDLE, SCAN_WORD, SCAN_NUMBER, SCAN_STRING, SCAN_SPACE
   } scan_mode_type;

   localparam int TEXT_LIMIT   = stt_pkg::MAX_TEXT_DEF;
   localparam int ITEM_TARGET  = 330;
   localparam int MAX_WAIT     = 13;
   localparam int DRAIN_CYCLES = 80;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QUOTE = 8'h27;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_COLON = 8'h3A;

   string keyword_text [9] = '{
      "meta", "id", "seq", "type", "file-extension",
      "endian", "size", "types", "contents"
   };

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   stt_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   stt_pkg::rsp_type rsp_data;

   // lexer state mirror
   scan_mode_type lex_mode     = SCAN_IDLE;
   logic [7:0]    text_buf [64];
   int            text_len     = 0;
   logic [31:0]   number_value = '0;
   bit            text_cut     = 1'b0;

   stt_pkg::rsp_type step_tokens[$];
   stt_pkg::rsp_type expected_tokens[$];

   int error_count = 0;
   int items_sent  = 0;
   int rsp_hold    = 0;
   bit calm        = 1'b0;

   schema_text_tokenizer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic note_mismatch(input string msg);
      error_count++;
      $display("mismatch at %0t: %s", $time, msg);
   endtask

   function automatic bit is_letter(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
   endfunction

   function automatic bit is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic void add_token(input logic [4:0] kind, input logic [31:0] ival,
                                     input logic [7:0] ch, input logic tv,
                                     input logic tend, input logic [1:0] err);
      stt_pkg::rsp_type t;
      t = '{token_kind: kind, int_value: ival, text_char: ch, text_valid: tv,
            token_end: tend, error_code: err, last: 1'b0};
      step_tokens.push_back(t);
   endfunction

   function automatic void keep_char(input logic [7:0] c);
      if (text_len < TEXT_LIMIT) begin
         text_buf[text_len] = c;
         text_len++;
      end else begin
         text_cut = 1'b1;
      end
   endfunction

   function automatic void replay_text(input logic [4:0] kind);
      logic [1:0] err;
      err = text_cut ? stt_pkg::ERR_TRUNC : stt_pkg::ERR_NONE;
      if (text_len == 0) begin
         add_token(kind, '0, '0, 1'b0, 1'b1, err);
      end else begin
         for (int i = 0; i < text_len; i++) begin
            add_token(kind, '0, text_buf[i], 1'b1, i == text_len - 1,
                      (i == text_len - 1) ? err : stt_pkg::ERR_NONE);
         end
      end
   endfunction

   function automatic void close_word();
      bit hit;
      if (!text_cut) begin
         for (int k = 0; k < 9; k++) begin
            if (keyword_text[k].len() == text_len) begin
               hit = 1'b1;
               for (int i = 0; i < text_len; i++) begin
                  if (keyword_text[k][i] != text_buf[i]) hit = 1'b0;
               end
               if (hit) begin
                  add_token(stt_pkg::K_KEYWORD0 + 5'(k), '0, '0, 1'b0, 1'b1,
                            stt_pkg::ERR_NONE);
                  return;
               end
            end
         end
      end
      replay_text(stt_pkg::K_IDENT);
   endfunction

   function automatic void lex_fresh(input logic [7:0] c);
      if (c == CH_COLON) begin
         add_token(stt_pkg::K_COLON, '0, '0, 1'b0, 1'b1, stt_pkg::ERR_NONE);
      end else if (c == CH_DASH) begin
         add_token(stt_pkg::K_DASH, '0, '0, 1'b0, 1'b1, stt_pkg::ERR_NONE);
      end else if (c == CH_TAB) begin
         add_token(stt_pkg::K_TAB, '0, '0, 1'b0, 1'b1, stt_pkg::ERR_NONE);
      end else if (c == CH_LF) begin
         add_token(stt_pkg::K_NEWLINE, '0, '0, 1'b0, 1'b1, stt_pkg::ERR_NONE);
      end else if (c == CH_CR) begin
         lex_mode = SCAN_IDLE;
      end else if (c == CH_SPACE) begin
         lex_mode = SCAN_SPACE;
      end else if (c == CH_QUOTE) begin
         text_len = 0;
         text_cut = 1'b0;
         lex_mode = SCAN_STRING;
      end else if (is_digit(c)) begin
         number_value = 32'(c - 8'h30);
         lex_mode = SCAN_NUMBER;
      end else if (is_letter(c)) begin
         text_len = 0;
         text_cut = 1'b0;
         keep_char(c);
         lex_mode = SCAN_WORD;
      end else begin
         add_token(stt_pkg::K_COLON, '0, '0, 1'b0, 1'b1, stt_pkg::ERR_SYMBOL);
      end
   endfunction

   function automatic void predict_tokens(input stt_pkg::req_type r);
      logic [7:0] c;
      bit         eoi;
      c = r.in_byte;
      eoi = r.end_of_input || c == CH_NUL;
      step_tokens.delete();
      if (eoi) begin
         if (lex_mode == SCAN_WORD) close_word();
         else if (lex_mode == SCAN_NUMBER)
            add_token(stt_pkg::K_INT, number_value, '0, 1'b0, 1'b1, stt_pkg::ERR_NONE);
         else if (lex_mode == SCAN_STRING)
            add_token(stt_pkg::K_STRING, '0, '0, 1'b0, 1'b1, stt_pkg::ERR_QUOTE);
         lex_mode = SCAN_IDLE;
         text_len = 0;
         text_cut = 1'b0;
         number_value = '0;
      end else if (lex_mode == SCAN_STRING) begin
         if (c == CH_QUOTE) begin
            replay_text(stt_pkg::K_STRING);
            lex_mode = SCAN_IDLE;
         end else begin
            keep_char(c);
         end
      end else if (lex_mode == SCAN_WORD && (is_letter(c) || is_digit(c) || c == CH_DASH)) begin
         keep_char(c);
      end else if (lex_mode == SCAN_NUMBER && is_digit(c)) begin
         number_value = number_value * 32'd10 + 32'(c - 8'h30);
      end else if (lex_mode == SCAN_SPACE && c == CH_SPACE) begin
         add_token(stt_pkg::K_TAB, '0, '0, 1'b0, 1'b1, stt_pkg::ERR_NONE);
         lex_mode = SCAN_IDLE;
      end else begin
         if (lex_mode == SCAN_WORD) close_word();
         else if (lex_mode == SCAN_NUMBER)
            add_token(stt_pkg::K_INT, number_value, '0, 1'b0, 1'b1, stt_pkg::ERR_NONE);
         else if (lex_mode == SCAN_SPACE)
            add_token(stt_pkg::K_BLANK, '0, '0, 1'b0, 1'b1, stt_pkg::ERR_NONE);
         lex_mode = SCAN_IDLE;
         lex_fresh(c);
      end
      if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
      foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
   endfunction

   // predict on each accepted byte, check each accepted token
   always @(posedge clock) begin
      stt_pkg::rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) predict_tokens(req_data);
         if (rsp_valid && !rsp_stall) begin
            rsp_hold = calm ? 0 : $urandom_range(0, MAX_WAIT);
            if (expected_tokens.size() == 0) begin
               note_mismatch("token transfer with nothing expected");
            end else begin
               want = expected_tokens.pop_front();
               if (rsp_data.token_kind !== want.token_kind)
                  note_mismatch($sformatf("token_kind got %0d want %0d",
                                          rsp_data.token_kind, want.token_kind));
               if (rsp_data.int_value !== want.int_value)
                  note_mismatch($sformatf("int_value got %0d want %0d",
                                          rsp_data.int_value, want.int_value));
               if (rsp_data.text_char !== want.text_char)
                  note_mismatch($sformatf("text_char got %h want %h",
                                          rsp_data.text_char, want.text_char));
               if (rsp_data.text_valid !== want.text_valid)
                  note_mismatch($sformatf("text_valid got %b want %b",
                                          rsp_data.text_valid, want.text_valid));
               if (rsp_data.token_end !== want.token_end)
                  note_mismatch($sformatf("token_end got %b want %b",
                                          rsp_data.token_end, want.token_end));
               if (rsp_data.error_code !== want.error_code)
                  note_mismatch($sformatf("error_code got %0d want %0d",
                                          rsp_data.error_code, want.error_code));
               if (rsp_data.last !== want.last)
                  note_mismatch($sformatf("last got %b want %b",
                                          rsp_data.last, want.last));
            end
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic eoi = 1'b0);
      int gap;
      gap = calm ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  <= '{in_byte: b, end_of_input: eoi};
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic send_str(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_tokens.size() != 0) @(negedge clock);
   endtask

   function automatic logic [7:0] word_char(input bit head);
      string pool;
      pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789-";
      return pool[$urandom_range(0, head ? 52 : 63)];
   endfunction

   function automatic int text_size();
      return ($urandom_range(0, 19) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 8);
   endfunction

   task automatic send_word(input int len);
      send_byte(word_char(1'b1));
      for (int i = 1; i < len; i++) send_byte(word_char(1'b0));
   endtask

   task automatic send_number(input int digits);
      for (int i = 0; i < digits; i++) send_byte(8'($urandom_range(48, 57)));
   endtask

   task automatic send_quoted(input int len, input bit close);
      logic [7:0] c;
      send_byte(CH_QUOTE);
      for (int i = 0; i < len; i++) begin
         do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE);
         send_byte(c);
      end
      if (close) send_byte(CH_QUOTE);
   endtask

   task automatic send_key();
      if ($urandom_range(0, 2) != 0) begin
         send_str(keyword_text[$urandom_range(0, 8)]);
         if ($urandom_range(0, 5) == 0) send_byte(word_char(1'b0));
      end else begin
         send_word(text_size());
      end
   endtask

   task automatic send_value();
      case ($urandom_range(0, 3))
         0: send_number(($urandom_range(0, 9) == 0) ? 11 : $urandom_range(1, 4));
         1: send_word(text_size());
         2: send_quoted(text_size() - 1, 1'b1);
         default: send_str(keyword_text[$urandom_range(0, 8)]);
      endcase
   endtask

   task automatic send_schema_line();
      int depth;
      depth = $urandom_range(0, 3);
      repeat (depth) send_str("  ");
      if ($urandom_range(0, 3) == 0) begin
         send_byte(CH_DASH);
         send_byte(CH_SPACE);
      end
      send_key();
      send_byte(CH_COLON);
      if ($urandom_range(0, 4) != 0) begin
         send_byte(CH_SPACE);
         send_value();
      end
      if ($urandom_range(0, 9) == 0) send_byte(CH_CR);
      send_byte(CH_LF);
   endtask

   task automatic send_noise();
      case ($urandom_range(0, 5))
         0: send_byte(8'($urandom_range(0, 255)));
         1: send_byte(8'($urandom_range(0, 255)), 1'b1);
         2: send_byte(CH_TAB);
         3: begin
            send_quoted($urandom_range(0, 5), 1'b0);
            send_byte(CH_NUL);
         end
         4: begin
            send_number($urandom_range(1, 3));
            send_byte(8'($urandom_range(0, 255)), 1'b1);
         end
         default: send_byte(CH_CR);
      endcase
   endtask

   task automatic test_punctuation();
      send_byte(CH_COLON);
      send_byte(CH_DASH);
      send_byte(CH_TAB);
      send_str("   ");
      send_byte(CH_LF);
      send_byte(CH_CR);
      send_byte(8'h80);
   endtask

   task automatic test_words_and_numbers();
      send_str("id:x-9 42");
      send_byte(CH_CR);
   endtask

   task automatic test_strings();
      send_str("''");
      send_byte(CH_QUOTE);
      send_byte(8'h61);
      send_byte(CH_CR);
      send_byte(CH_QUOTE);
   endtask

   task automatic test_end_of_input();
      send_str("'q");
      send_byte(CH_NUL);
      send_str("z");
      send_byte(8'hFF, 1'b1);
   endtask

   task automatic test_long_tokens();
      send_word(TEXT_LIMIT + 1);
      send_byte(CH_LF);
      send_quoted(TEXT_LIMIT + 2, 1'b1);
      send_number(11);
      send_byte(CH_NUL, 1'b1);
   endtask

   task automatic test_random_schema(input int stop_at);
      bit paused;
      paused = 1'b0;
      calm = 1'b1;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 11) == 0) calm = ~calm;
         if (!paused && items_sent > stop_at - ITEM_TARGET / 2) begin
            wait_drained();
            paused = 1'b1;
         end
         if ($urandom_range(0, 9) < 7) send_schema_line();
         else send_noise();
      end
      calm = 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_punctuation();
      test_words_and_numbers();
      test_strings();
      test_end_of_input();
      wait_drained();
      test_long_tokens();
      test_random_schema(ITEM_TARGET);
      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (expected_tokens.size() != 0)
         note_mismatch($sformatf("%0d tokens never arrived", expected_tokens.size()));
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #15_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

### filelist.f
hw/rtl/stt_pkg.sv
hw/rtl/stt_ctrl.sv
hw/rtl/stt_dp.sv
hw/rtl/schema_text_tokenizer.sv
bench/tb_schema_text_tokenizer.sv
